// ----- design/khs_pkg.sv -----
// ----------------------------------------------------------------------------
// khs_pkg
// Shared types and constants of the streaming k-th largest block.
// ----------------------------------------------------------------------------
package khs_pkg;

  localparam int K_MAX  = 16;
  localparam int DATA_W = 32;
  localparam int RANK_W = 5;
  localparam int ADDR_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CNT_W  = $clog2(K_MAX + 1);
  localparam int IDX_W  = ADDR_W + 2;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(3);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth_value;
    logic                     kth_valid;
  } out_beat_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- design/kth_largest_stream_min_heap.sv -----
// ----------------------------------------------------------------------------
// kth_largest_stream_min_heap
// Running k-th largest of a signed sample stream, kept in a min-heap.
//
//   Channel  Direction  Handshake           Beat
//   in       input      in_valid/in_stall   sample, last_of_stream
//   out      output     out_valid/out_stall kth_value, kth_valid
//   cfg      input      cfg_valid/ready     kth_rank
//
// A sample that is only stored, or does not beat the root, goes on to output.
// A replacement sifts down, reading both children at each heap level walked;
// the heap build on the k-th sample loads and sifts each parent in turn.
// The single comparator and the single RAM read port serialise these steps.
// Reset sets the rank to 3 and clears the sample count, not the heap RAM.
// A pending configuration beat stalls the input, and the result waits in an
// output register while the next beat enters.
// ----------------------------------------------------------------------------
module kth_largest_stream_min_heap
  import khs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_beat_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RANK_W-1:0] cfg_data_i
);

  logic [RANK_W-1:0] rank_q;
  logic [CNT_W-1:0]  rank_eff;
  logic              idle;
  logic              cfg_write;
  logic              res_valid;
  logic              res_ready;
  out_beat_t         res;
  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;
  logic              oval_q;
  out_beat_t         obeat_q;

  assign cfg_ready_o = idle;
  assign in_stall_o  = !idle || cfg_valid_i;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    if (rank_q == '0) begin
      rank_eff = CNT_W'(1);
    end else if (32'(rank_q) > K_MAX) begin
      rank_eff = CNT_W'(K_MAX);
    end else begin
      rank_eff = CNT_W'(rank_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_RESET;
    end else if (cfg_write) begin
      rank_q <= cfg_data_i;
    end
  end

  khs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rank_i      (rank_eff),
    .start_i     (in_valid_i && !in_stall_o),
    .item_i      (in_beat_i),
    .cfg_clear_i (cfg_write),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  khs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (K_MAX)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !oval_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      oval_q <= 1'b1;
    end else if (!out_stall_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      obeat_q <= res;
    end
  end

  assign out_valid_o = oval_q;
  assign out_beat_o  = obeat_q;

endmodule

// ----- design/khs_ram.sv -----
// ----------------------------------------------------------------------------
// khs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module khs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/khs_core.sv -----
// ----------------------------------------------------------------------------
// khs_core
// Sequencer and shared comparator that store, build and sift the min-heap.
// ----------------------------------------------------------------------------
module khs_core
  import khs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  rank_i,
  input  logic              start_i,
  input  in_beat_t          item_i,
  input  logic              cfg_clear_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output out_beat_t         res_o,
  output ram_req_t          ram_req_o,
  input  logic [DATA_W-1:0] ram_rdata_i
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_TEST  = 10'b0000000010,
    ST_LOAD  = 10'b0000000100,
    ST_LOADW = 10'b0000001000,
    ST_RDL   = 10'b0000010000,
    ST_RDR   = 10'b0000100000,
    ST_CMPR  = 10'b0001000000,
    ST_CMPP  = 10'b0010000000,
    ST_FIN   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   seen_q, seen_d;
  logic [CNT_W-1:0]   bp_q, bp_d;
  logic               build_q, build_d;
  logic               last_q, last_d;
  logic               valid_q, valid_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0]  cidx_q, cidx_d;
  logic [DATA_W-1:0]  cur_q, cur_d;
  logic [DATA_W-1:0]  child_q, child_d;
  logic [DATA_W-1:0]  root_q;

  logic [IDX_W-1:0]   left_idx;
  logic [IDX_W-1:0]   right_idx;
  logic [IDX_W-1:0]   k_idx;
  logic [CNT_W:0]     seen_inc;
  logic [CNT_W-1:0]   half_k;
  logic [DATA_W-1:0]  cmp_a;
  logic [DATA_W-1:0]  cmp_b;
  logic               cmp_lt;
  ram_req_t           req;

  assign left_idx  = (IDX_W'(pos_q) << 1) + IDX_W'(1);
  assign right_idx = left_idx + IDX_W'(1);
  assign k_idx     = IDX_W'(rank_i);
  assign seen_inc  = {1'b0, seen_q} + (CNT_W + 1)'(1);
  assign half_k    = rank_i >> 1;

  always_comb begin
    cmp_a = child_q;
    cmp_b = cur_q;
    case (state_q)
      ST_TEST: begin
        cmp_a = root_q;
        cmp_b = cur_q;
      end
      ST_CMPR: begin
        cmp_a = ram_rdata_i;
        cmp_b = child_q;
      end
      default: begin
        cmp_a = child_q;
        cmp_b = cur_q;
      end
    endcase
  end

  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    bp_d    = bp_q;
    build_d = build_q;
    last_d  = last_q;
    valid_d = valid_q;
    pos_d   = pos_q;
    cidx_d  = cidx_q;
    cur_d   = cur_q;
    child_d = child_q;
    req     = '0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_clear_i) begin
          seen_d = '0;
        end else if (start_i) begin
          cur_d  = item_i.sample;
          last_d = item_i.last_of_stream;
          if (seen_inc < {1'b0, rank_i}) begin
            req.we    = 1'b1;
            req.waddr = seen_q[ADDR_W-1:0];
            req.wdata = item_i.sample;
            seen_d    = seen_inc[CNT_W-1:0];
            valid_d   = 1'b0;
            state_d   = ST_OUT;
          end else if (seen_inc == {1'b0, rank_i}) begin
            req.we    = 1'b1;
            req.waddr = seen_q[ADDR_W-1:0];
            req.wdata = item_i.sample;
            seen_d    = rank_i;
            valid_d   = 1'b1;
            if (half_k == '0) begin
              state_d = ST_OUT;
            end else begin
              bp_d    = half_k;
              pos_d   = ADDR_W'(half_k - CNT_W'(1));
              build_d = 1'b1;
              state_d = ST_LOAD;
            end
          end else begin
            valid_d = 1'b1;
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        if (cmp_lt) begin
          pos_d   = '0;
          build_d = 1'b0;
          state_d = ST_RDL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_LOAD: begin
        req.re    = 1'b1;
        req.raddr = pos_q;
        state_d   = ST_LOADW;
      end
      ST_LOADW: begin
        cur_d   = ram_rdata_i;
        state_d = ST_RDL;
      end
      ST_RDL: begin
        if (left_idx >= k_idx) begin
          state_d = ST_FIN;
        end else begin
          req.re    = 1'b1;
          req.raddr = left_idx[ADDR_W-1:0];
          cidx_d    = left_idx[ADDR_W-1:0];
          state_d   = ST_RDR;
        end
      end
      ST_RDR: begin
        child_d = ram_rdata_i;
        if (right_idx < k_idx) begin
          req.re    = 1'b1;
          req.raddr = right_idx[ADDR_W-1:0];
        end
        state_d = ST_CMPR;
      end
      ST_CMPR: begin
        if ((right_idx < k_idx) && cmp_lt) begin
          child_d = ram_rdata_i;
          cidx_d  = right_idx[ADDR_W-1:0];
        end
        state_d = ST_CMPP;
      end
      ST_CMPP: begin
        if (cmp_lt) begin
          req.we    = 1'b1;
          req.waddr = pos_q;
          req.wdata = child_q;
          pos_d     = cidx_q;
          state_d   = ST_RDL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        req.we    = 1'b1;
        req.waddr = pos_q;
        req.wdata = cur_q;
        if (build_q && (bp_q > CNT_W'(1))) begin
          bp_d    = bp_q - CNT_W'(1);
          pos_d   = ADDR_W'(bp_q - CNT_W'(2));
          state_d = ST_LOAD;
        end else begin
          build_d = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_ready_i) begin
          if (last_q) begin
            seen_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
      bp_q    <= '0;
      build_q <= 1'b0;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      bp_q    <= bp_d;
      build_q <= build_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cidx_q  <= cidx_d;
    cur_q   <= cur_d;
    child_q <= child_d;
    if (req.we && (req.waddr == '0)) begin
      root_q <= req.wdata;
    end
  end

  assign ram_req_o       = req;
  assign idle_o          = (state_q == ST_IDLE);
  assign res_valid_o     = (state_q == ST_OUT);
  assign res_o.kth_value = valid_q ? root_q : '0;
  assign res_o.kth_valid = valid_q;

endmodule

// ----- design/khs_checker.sv -----
// ----------------------------------------------------------------------------
// khs_checker
// Port-level checks of the streaming k-th largest block, bound to the top.
// ----------------------------------------------------------------------------
module khs_checker
  import khs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input out_beat_t         out_beat_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("Stalled output beat changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("Block took no busy cycle after an input beat.");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> cfg_ready_o && !cfg_valid_i)
    else $error("Input open while the block is busy or a write is offered.");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.kth_valid |-> out_beat_o.kth_value == '0)
    else $error("Invalid result carries a nonzero value.");

endmodule

bind kth_largest_stream_min_heap khs_checker u_khs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
